FILE: hw/rtl/tevq_pkg.sv
// Package: shared types and constants of the timed event queue.
`timescale 1ns / 1ps
`default_nettype none
package tevq_pkg;

    // Most results one poll may produce
    localparam int MAX_RESULTS = 32;
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

    // Result status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    // Input opcodes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_POLL   = 1'b1;

    // Event payload kept in each cell, apart from its time
    typedef struct packed {
        logic       kind;
        logic [3:0] chan;
        logic [6:0] pitch;
        logic [6:0] loudness;
        logic [7:0] tag;
        logic       tag_valid;
    } evt_t;

    // Per-cycle command to every cell of the chain
    typedef struct packed {
        logic ins;
        logic pop;
    } cell_ctrl_t;

endpackage
`default_nettype wire

FILE: hw/rtl/tevq_in_if.sv
// Interface: input item channel (insert or poll) with valid/ready handshake.
`timescale 1ns / 1ps
`default_nettype none
interface tevq_in_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [31:0] stamp;
    logic        kind;
    logic [3:0]  chan;
    logic [6:0]  pitch;
    logic [6:0]  loudness;
    logic [7:0]  tag;
    logic        tag_valid;

    modport source (
        output valid, opcode, stamp, kind, chan, pitch, loudness, tag, tag_valid,
        input  ready
    );
    modport sink (
        input  valid, opcode, stamp, kind, chan, pitch, loudness, tag, tag_valid,
        output ready
    );
endinterface
`default_nettype wire

FILE: hw/rtl/tevq_out_if.sv
// Interface: result item channel with valid/ready handshake.
`timescale 1ns / 1ps
`default_nettype none
interface tevq_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic       send;
    logic       out_kind;
    logic [3:0] out_chan;
    logic [6:0] out_pitch;
    logic [6:0] out_loudness;
    logic [7:0] release_tag;
    logic       release_valid;
    logic       last;

    modport source (
        output valid, status, send, out_kind, out_chan, out_pitch, out_loudness,
               release_tag, release_valid, last,
        input  ready
    );
    modport sink (
        input  valid, status, send, out_kind, out_chan, out_pitch, out_loudness,
               release_tag, release_valid, last,
        output ready
    );
endinterface
`default_nettype wire

FILE: hw/rtl/tevq_cell.sv
// Module: one cell of the sorted event chain, holding one event.
`timescale 1ns / 1ps
`default_nettype none
module tevq_cell #(
    parameter int TIME_BITS = 32
) (
    input  wire                     clk,
    input  tevq_pkg::cell_ctrl_t    ctrl,
    input  wire                     occ,
    input  wire [TIME_BITS-1:0]     stamp,
    input  tevq_pkg::evt_t          new_evt,
    input  wire                     prev_lt,
    input  wire [TIME_BITS-1:0]     prev_time,
    input  tevq_pkg::evt_t          prev_evt,
    input  wire [TIME_BITS-1:0]     next_time,
    input  tevq_pkg::evt_t          next_evt,
    output logic [TIME_BITS-1:0]    time_q,
    output tevq_pkg::evt_t          evt_q,
    output logic                    lt,
    output logic                    le
);

    logic [TIME_BITS-1:0] time_reg;
    logic [TIME_BITS-1:0] time_next;
    tevq_pkg::evt_t       evt_reg;
    tevq_pkg::evt_t       evt_next;

    // Compare the held time against the command stamp
    assign lt     = occ && (time_reg < stamp);
    assign le     = (time_reg <= stamp);
    assign time_q = time_reg;
    assign evt_q  = evt_reg;

    // Pop shifts toward the head; insert keeps earlier cells, loads the new
    // event at the first cell that is not earlier (prev_lt high) and shifts the rest back
    always_comb
    begin
        time_next = time_reg;
        evt_next  = evt_reg;
        if (ctrl.pop)
        begin
            time_next = next_time;
            evt_next  = next_evt;
        end
        else if (ctrl.ins && !lt)
        begin
            if (prev_lt)
            begin
                time_next = stamp;
                evt_next  = new_evt;
            end
            else
            begin
                time_next = prev_time;
                evt_next  = prev_evt;
            end
        end
    end

    // Hold the event
    always_ff @(posedge clk)
    begin
        time_reg <= time_next;
        evt_reg  <= evt_next;
    end

endmodule
`default_nettype wire

FILE: hw/rtl/timed_event_queue_top.sv
// Top level: time-ordered note event queue built from a chain of cells.
// An accepted item moves control from idle to the insert or poll state, which
// loads the result register once it is free; no new item is taken until idle.
// A poll pops the head cell once per cycle while the result register is free.
// Insert places the event in all cells at once, in one compare-and-shift step.
// Reset clears the fill count, enable, control state and output valid.
`timescale 1ns / 1ps
`default_nettype none
module timed_event_queue_top #(
    parameter int QUEUE_DEPTH = 32,
    parameter int TIME_BITS   = 32
) (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              cfg_we,
    input  wire              cfg_wdata,
    tevq_in_if.sink          item,
    tevq_out_if.source       result
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_INSERT = 3'b010,
        ST_POLL   = 3'b100
    } state_t;

    state_t                           state_reg, state_next;
    logic                             enable_reg;
    logic [CNT_W-1:0]                 count_reg, count_next;
    logic [tevq_pkg::RES_CNT_W-1:0]   n_reg, n_next;
    logic [TIME_BITS-1:0]             stamp_reg;
    tevq_pkg::evt_t                   evt_reg;

    logic                             out_valid_reg, out_valid_next;
    logic [1:0]                       out_status_reg, out_status_next;
    tevq_pkg::evt_t                   out_evt_reg, out_evt_next;
    logic                             out_send_reg, out_send_next;
    logic                             out_last_reg, out_last_next;

    tevq_pkg::cell_ctrl_t             ctrl;
    logic [TIME_BITS-1:0]             cell_time [QUEUE_DEPTH];
    tevq_pkg::evt_t                   cell_evt  [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0]           cell_lt;
    logic [QUEUE_DEPTH-1:0]           cell_le;
    logic [QUEUE_DEPTH-1:0]           occ;

    logic                             accept;
    logic                             out_free;
    logic                             full;
    logic                             due0;
    logic                             due1;
    tevq_pkg::evt_t                   in_evt;

    assign accept   = item.valid && item.ready;
    assign out_free = !out_valid_reg || result.ready;
    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));

    assign in_evt.kind      = item.kind;
    assign in_evt.chan      = item.chan;
    assign in_evt.pitch     = item.pitch;
    assign in_evt.loudness  = item.loudness;
    assign in_evt.tag       = item.tag;
    assign in_evt.tag_valid = item.tag_valid;

    // Build the cell chain
    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            logic                 p_lt;
            logic [TIME_BITS-1:0] p_time;
            tevq_pkg::evt_t       p_evt;
            logic [TIME_BITS-1:0] n_time;
            tevq_pkg::evt_t       n_evt;

            assign occ[gi] = (count_reg > CNT_W'(gi));

            // Head cell sees an always-earlier neighbor so it takes the new event
            if (gi == 0)
            begin : g_head
                assign p_lt   = 1'b1;
                assign p_time = stamp_reg;
                assign p_evt  = evt_reg;
            end
            else
            begin : g_body
                assign p_lt   = cell_lt[gi-1];
                assign p_time = cell_time[gi-1];
                assign p_evt  = cell_evt[gi-1];
            end

            // Tail cell recirculates its own content on a pop
            if (gi == QUEUE_DEPTH - 1)
            begin : g_tail
                assign n_time = cell_time[gi];
                assign n_evt  = cell_evt[gi];
            end
            else
            begin : g_mid
                assign n_time = cell_time[gi+1];
                assign n_evt  = cell_evt[gi+1];
            end

            tevq_cell #(
                .TIME_BITS (TIME_BITS)
            ) u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .occ       (occ[gi]),
                .stamp     (stamp_reg),
                .new_evt   (evt_reg),
                .prev_lt   (p_lt),
                .prev_time (p_time),
                .prev_evt  (p_evt),
                .next_time (n_time),
                .next_evt  (n_evt),
                .time_q    (cell_time[gi]),
                .evt_q     (cell_evt[gi]),
                .lt        (cell_lt[gi]),
                .le        (cell_le[gi])
            );
        end
    endgenerate

    // Head and second cell due under the current poll
    assign due0 = enable_reg && occ[0] && cell_le[0]
                  && (n_reg < tevq_pkg::RES_CNT_W'(tevq_pkg::MAX_RESULTS));
    assign due1 = enable_reg && occ[1] && cell_le[1]
                  && (n_reg < tevq_pkg::RES_CNT_W'(tevq_pkg::MAX_RESULTS - 1));

    assign item.ready = (state_reg == ST_IDLE);

    // Sequence inserts and polls, fill the result register
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        n_next          = n_reg;
        ctrl            = '0;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_evt_next    = out_evt_reg;
        out_send_next   = out_send_reg;
        out_last_next   = out_last_reg;

        if (result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    n_next     = '0;
                    state_next = (item.opcode == tevq_pkg::OP_POLL) ? ST_POLL : ST_INSERT;
                end
            end
            ST_INSERT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = full ? tevq_pkg::STAT_FULL : tevq_pkg::STAT_OK;
                    out_evt_next    = '0;
                    out_send_next   = 1'b0;
                    out_last_next   = 1'b1;
                    if (!full)
                    begin
                        ctrl.ins   = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_POLL:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (due0)
                    begin
                        out_status_next = tevq_pkg::STAT_OK;
                        out_evt_next    = cell_evt[0];
                        out_send_next   = (cell_evt[0].pitch != 7'd0);
                        out_last_next   = !due1;
                        ctrl.pop        = 1'b1;
                        count_next      = count_reg - CNT_W'(1);
                        n_next          = n_reg + tevq_pkg::RES_CNT_W'(1);
                        if (!due1)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    else
                    begin
                        out_status_next = tevq_pkg::STAT_EMPTY;
                        out_evt_next    = '0;
                        out_send_next   = 1'b0;
                        out_last_next   = 1'b1;
                        state_next      = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Advance control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            enable_reg    <= 1'b0;
            count_reg     <= '0;
            n_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            n_reg         <= n_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                enable_reg <= cfg_wdata;
            end
        end
    end

    // Hold the accepted item and the result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stamp_reg <= TIME_BITS'(item.stamp);
            evt_reg   <= in_evt;
        end
        out_status_reg <= out_status_next;
        out_evt_reg    <= out_evt_next;
        out_send_reg   <= out_send_next;
        out_last_reg   <= out_last_next;
    end

    // Drive the result channel
    assign result.valid         = out_valid_reg;
    assign result.status        = out_status_reg;
    assign result.send          = out_send_reg;
    assign result.out_kind      = out_evt_reg.kind;
    assign result.out_chan      = out_evt_reg.chan;
    assign result.out_pitch     = out_evt_reg.pitch;
    assign result.out_loudness  = out_evt_reg.loudness;
    assign result.release_tag   = out_evt_reg.tag;
    assign result.release_valid = out_evt_reg.tag_valid;
    assign result.last          = out_last_reg;

endmodule
`default_nettype wire
